// ===== rtl/core/sdiv128_pkg.sv =====
// Shared types and constants for the signed 128-bit divider.
// Used by the controller, the datapath and the top level.
package sdiv128_pkg;

  localparam int unsigned WordBits = 128;
  localparam int unsigned HalfBits = 64;
  localparam int unsigned CountBits = 7;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusDivZero  = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_zero;
  } dp_stat_t;

endpackage

// ===== rtl/core/sdiv128_ctrl.sv =====
// Controller for the signed 128-bit divider: sequences load, bit steps and finish.
// Depends on sdiv128_pkg.
module sdiv128_ctrl
  import sdiv128_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  typedef enum logic [1:0] {
    Idle,
    Run,
    Finish
  } state_e;

  state_e             state_q;
  logic [CountBits-1:0] count_q;
  logic               done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        Idle: begin
          if (start_i) begin
            state_q <= Run;
            count_q <= '0;
          end
        end
        Run: begin
          // A zero divisor skips the bit loop.
          if (stat_i.div_zero || (count_q == CountBits'(WordBits - 1))) begin
            state_q <= Finish;
          end
          count_q <= count_q + 1'b1;
        end
        Finish: begin
          state_q <= Idle;
          done_q  <= 1'b1;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assign cmd_o.load   = (state_q == Idle) && start_i;
  assign cmd_o.step   = (state_q == Run) && !stat_i.div_zero;
  assign cmd_o.finish = (state_q == Finish);
  assign busy_o       = (state_q != Idle);
  assign done_o       = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.load |=> busy_o)
    else $error("load did not start work");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.finish |=> done_o)
    else $error("finish did not raise done");

endmodule

// ===== rtl/core/sdiv128_dp.sv =====
// Datapath for the signed 128-bit divider: magnitudes, restoring bit steps, signs.
// Depends on sdiv128_pkg.
module sdiv128_dp
  import sdiv128_pkg::*;
(
  input  logic                clk_i,
  input  dp_cmd_t             cmd_i,
  input  logic [WordBits-1:0] dividend_i,
  input  logic [WordBits-1:0] divisor_i,
  output dp_stat_t            stat_o,
  output logic [WordBits-1:0] quotient_o,
  output logic [WordBits-1:0] remainder_o,
  output status_e             status_o
);

  logic [WordBits-1:0] num_q, den_q, rem_q, quo_q, quo_d, rem_d;
  logic                qneg_q, rneg_q;
  logic [WordBits:0]   shifted, diff;
  status_e             status_q;

  // The numerator register shifts out its top bit each step and collects
  // quotient bits at the bottom.
  assign shifted = {rem_q, num_q[WordBits-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    quo_d = qneg_q ? (~num_q + 1'b1) : num_q;
    rem_d = rneg_q ? (~rem_q + 1'b1) : rem_q;
    if (den_q == '0) begin
      quo_d = '0;
      rem_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q  <= dividend_i[WordBits-1] ? (~dividend_i + 1'b1) : dividend_i;
      den_q  <= divisor_i[WordBits-1] ? (~divisor_i + 1'b1) : divisor_i;
      rem_q  <= '0;
      qneg_q <= dividend_i[WordBits-1] ^ divisor_i[WordBits-1];
      rneg_q <= dividend_i[WordBits-1];
    end else if (cmd_i.step) begin
      if (!diff[WordBits]) begin
        rem_q <= diff[WordBits-1:0];
        num_q <= {num_q[WordBits-2:0], 1'b1};
      end else begin
        rem_q <= shifted[WordBits-1:0];
        num_q <= {num_q[WordBits-2:0], 1'b0};
      end
    end else if (cmd_i.finish) begin
      quo_q    <= quo_d;
      rem_q    <= rem_d;
      status_q <= (den_q == '0) ? StatusDivZero : StatusOk;
    end
  end

  assign stat_o.div_zero = (den_q == '0);
  assign quotient_o      = quo_q;
  assign remainder_o     = rem_q;
  assign status_o        = status_q;

endmodule

// ===== rtl/core/signed_divide_128.sv =====
// Signed 128-bit divider, one quotient bit per cycle.
// From start to done_o: load, 128 bit steps, sign fixup; a zero divisor skips the bit steps.
// Busy is high while a word is in work; a new word is taken only while busy is low.
// The result is shown for the single cycle that done_o is high; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) returns the controller to idle; no result is pending.
module signed_divide_128
  import sdiv128_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [63:0] dividend_high_i,
  input  logic        [63:0] dividend_low_i,
  input  logic signed [63:0] divisor_high_i,
  input  logic        [63:0] divisor_low_i,
  output logic               done_o,
  output logic signed [63:0] quotient_high_o,
  output logic        [63:0] quotient_low_o,
  output logic signed [63:0] remainder_high_o,
  output logic        [63:0] remainder_low_o,
  output logic        [1:0]  status_o
);

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic [WordBits-1:0] quo, rem;
  status_e             st;

  sdiv128_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  sdiv128_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .dividend_i ({dividend_high_i, dividend_low_i}),
    .divisor_i  ({divisor_high_i, divisor_low_i}),
    .stat_o     (stat),
    .quotient_o (quo),
    .remainder_o(rem),
    .status_o   (st)
  );

  assign quotient_high_o  = quo[WordBits-1:HalfBits];
  assign quotient_low_o   = quo[HalfBits-1:0];
  assign remainder_high_o = rem[WordBits-1:HalfBits];
  assign remainder_low_o  = rem[HalfBits-1:0];
  assign status_o         = st;

endmodule

// ===== tb/sdiv128_checker.sv =====
// Checker for the signed 128-bit divider: watches accepted words and results.
// Predicts quotient, remainder and status from the operands; needs sdiv128_pkg.
module sdiv128_checker
  import sdiv128_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [63:0] dividend_high_i,
  input  logic        [63:0] dividend_low_i,
  input  logic signed [63:0] divisor_high_i,
  input  logic        [63:0] divisor_low_i,
  input  logic               done_i,
  input  logic signed [63:0] quotient_high_i,
  input  logic        [63:0] quotient_low_i,
  input  logic signed [63:0] remainder_high_i,
  input  logic        [63:0] remainder_low_i,
  input  logic        [1:0]  status_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [127:0] quot;
    logic [127:0] rem;
    status_e      stat;
  } div_result_t;

  div_result_t quot_rem_q[$];

  // Truncating division on magnitudes; signs are restored afterwards.
  function automatic div_result_t divide_signed(logic [127:0] num, logic [127:0] den);
    div_result_t res;
    logic num_neg;
    logic den_neg;
    logic [127:0] num_mag;
    logic [127:0] den_mag;
    logic [127:0] q;
    logic [127:0] r;
    num_neg = num[127];
    den_neg = den[127];
    num_mag = num_neg ? -num : num;
    den_mag = den_neg ? -den : den;
    if (den_mag == '0) begin
      res.quot = '0;
      res.rem = '0;
      res.stat = StatusDivZero;
      return res;
    end
    q = num_mag / den_mag;
    r = num_mag % den_mag;
    res.quot = (num_neg != den_neg) ? -q : q;
    res.rem = num_neg ? -r : r;
    res.stat = StatusOk;
    return res;
  endfunction

  assign pending_o = quot_rem_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    div_result_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      quot_rem_q.delete();
    end else begin
      if (start_i && !busy_i) begin
        quot_rem_q.push_back(divide_signed({dividend_high_i, dividend_low_i},
                                           {divisor_high_i, divisor_low_i}));
      end
      if (done_i) begin
        if (quot_rem_q.size() == 0) begin
          if (fail_count_o < 10) $display("Unexpected result word at %0t", $realtime);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = quot_rem_q.pop_front();
          if ({quotient_high_i, quotient_low_i} !== want.quot ||
              {remainder_high_i, remainder_low_i} !== want.rem ||
              status_i !== want.stat) begin
            if (fail_count_o < 10) begin
              $display("Mismatch: expected q=%h r=%h s=%0d, got q=%h r=%h s=%0d",
                       want.quot, want.rem, want.stat,
                       {quotient_high_i, quotient_low_i},
                       {remainder_high_i, remainder_low_i}, status_i);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_signed_divide_128.sv =====
// Top testbench for signed_divide_128: directed and random operand words.
// Depends on sdiv128_pkg, the block and sdiv128_checker.
module tb_signed_divide_128;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomWords = 1330;
  localparam int IdleLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [63:0] dividend_high = '0;
  logic [63:0] dividend_low = '0;
  logic signed [63:0] divisor_high = '0;
  logic [63:0] divisor_low = '0;
  logic done;
  logic signed [63:0] quotient_high;
  logic [63:0] quotient_low;
  logic signed [63:0] remainder_high;
  logic [63:0] remainder_low;
  logic [1:0] status;
  int fail_count;
  int pending;
  int idle_cycles = 0;
  int words_sent = 0;
  int zero_divs = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  signed_divide_128 u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .dividend_high_i(dividend_high), .dividend_low_i(dividend_low),
    .divisor_high_i(divisor_high), .divisor_low_i(divisor_low),
    .done_o(done), .quotient_high_o(quotient_high), .quotient_low_o(quotient_low),
    .remainder_high_o(remainder_high), .remainder_low_o(remainder_low),
    .status_o(status)
  );

  sdiv128_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy),
    .dividend_high_i(dividend_high), .dividend_low_i(dividend_low),
    .divisor_high_i(divisor_high), .divisor_low_i(divisor_low),
    .done_i(done), .quotient_high_i(quotient_high), .quotient_low_i(quotient_low),
    .remainder_high_i(remainder_high), .remainder_low_i(remainder_low),
    .status_i(status), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: cycles with neither an accepted word nor a result.
  always @(posedge clk_i) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Operands with random digit counts so short and long divisions both occur.
  function automatic logic [127:0] rand_operand();
    logic [127:0] v;
    int bits;
    v = rand128();
    case ($urandom_range(0, 5))
      0: bits = 128;
      1: bits = $urandom_range(1, 32);
      2: bits = $urandom_range(33, 64);
      3: bits = $urandom_range(65, 127);
      default: bits = $urandom_range(1, 128);
    endcase
    if (bits < 128) v = v & ((128'd1 << bits) - 128'd1);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic send_word(logic [127:0] num, logic [127:0] den);
    dividend_high <= num[127:64];
    dividend_low <= num[63:0];
    divisor_high <= den[127:64];
    divisor_low <= den[63:0];
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
    if (den == '0) zero_divs++;
  endtask

  task automatic idle_gap();
    start <= 1'b0;
    repeat ($urandom_range(1, 8)) @(negedge clk_i);
  endtask

  localparam logic [127:0] MinVal = {1'b1, 127'd0};
  localparam logic [127:0] MaxVal = {1'b0, {127{1'b1}}};
  localparam logic [127:0] MinusOne = '1;

  initial begin
    logic [127:0] num;
    logic [127:0] den;
    int burst;
    int n;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Edge operands: zero divisor, most negative by minus one, small over large.
    send_word(128'd7, '0);
    send_word(MinVal, '0);
    send_word(MinVal, MinusOne);
    send_word(MinVal, 128'd1);
    send_word(MaxVal, MinusOne);
    send_word(MaxVal, MinVal);
    send_word(MinVal, MinVal);
    send_word(MinVal, MaxVal);
    send_word(MinusOne, MinVal);
    send_word(128'd5, 128'd9);
    send_word(-128'd5, 128'd9);
    send_word(128'd5, -128'd9);
    send_word(-128'd17, -128'd5);
    send_word('0, 128'd3);
    send_word(MaxVal, 128'hffff_ffff);
    send_word(MaxVal, 128'h1_0000_0000);
    send_word({64'h0, 64'hffff_ffff_ffff_ffff}, {64'h0, 64'h8000_0000_0000_0001});
    send_word(MaxVal, {64'h1, 64'h0});
    send_word(128'h5555_aaaa_5555_aaaa_5555_aaaa_5555_aaaa, 128'h3_0000_0001);
    idle_gap();

    n = 0;
    while (n < RandomWords) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && n < RandomWords; i++) begin
        num = rand_operand();
        case ($urandom_range(0, 19))
          0: den = '0;
          1: den = MinusOne;
          2: den = num;
          default: den = rand_operand();
        endcase
        if ($urandom_range(0, 29) == 0) num = MinVal;
        send_word(num, den);
        n++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap();
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (140) @(negedge clk_i);
    $display("Ran %0d division words, %0d of them with a zero divisor.",
             words_sent, zero_divs);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
